### hdl/lswc_pkg.sv
// ============================================================================
// lswc_pkg: shared types and constants for the segment window clipper
// Coordinate defaults, outcode bit positions, verdict codes and register
// indexes used across the clipper pipeline.
// ============================================================================
package lswc_pkg;

    localparam int COORD_BITS_DEF = 16;

    // Window reset values
    localparam int WIN_LEFT_RST   = 150;
    localparam int WIN_RIGHT_RST  = 450;
    localparam int WIN_TOP_RST    = 100;
    localparam int WIN_BOTTOM_RST = 350;

    // Configuration register indexes
    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_RIGHT  = 2'd1;
    localparam logic [1:0] REG_TOP    = 2'd2;
    localparam logic [1:0] REG_BOTTOM = 2'd3;

    // Outcode bit positions
    localparam int OC_TOP    = 0;
    localparam int OC_BOTTOM = 1;
    localparam int OC_RIGHT  = 2;
    localparam int OC_LEFT   = 3;

    // Verdict codes
    localparam logic [1:0] VERDICT_REJECT = 2'd0;
    localparam logic [1:0] VERDICT_CLIP   = 2'd1;
    localparam logic [1:0] VERDICT_INSIDE = 2'd2;

    // Pipeline stage control moved with the data
    typedef struct packed {
        logic       valid;
        logic [1:0] verdict;
    } t_stage_ctl;

endpackage

### hdl/line_segment_window_clipper_unit.sv
// ============================================================================
// line_segment_window_clipper_unit: Cohen-Sutherland segment clipper
// Clips one segment per cycle, unless the output stalls, against a configured window, deep pipeline.
// ============================================================================
//  channel | signals                         | role
//  in      | i_valid/o_ready, i_start_*,i_end_* | segment request
//  out     | o_valid/i_ready, o_verdict, o_clipped_* | clipped result
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_data   | window registers
// Throughput: one request per cycle while the output is not stalled. The depth
// comes from the bit-per-stage pipelined dividers of the endpoint movers.
// Reset clears valid bits and loads the default window.
// A stall at the output freezes the whole pipeline; nothing is dropped.
module line_segment_window_clipper_unit #(
    parameter int COORD_BITS = lswc_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_index,
    input  logic [COORD_BITS-1:0]        i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [1:0]                   o_verdict,
    output logic signed [COORD_BITS-1:0] o_clipped_start_x,
    output logic signed [COORD_BITS-1:0] o_clipped_start_y,
    output logic signed [COORD_BITS-1:0] o_clipped_end_x,
    output logic signed [COORD_BITS-1:0] o_clipped_end_y
);

    localparam int LAT = 2 * (COORD_BITS + 1) + 3;   // control line depth: stage 0 plus mover

    // window registers
    logic signed [COORD_BITS-1:0] r_left, r_right, r_top, r_bottom;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= COORD_BITS'(lswc_pkg::WIN_LEFT_RST);
            r_right  <= COORD_BITS'(lswc_pkg::WIN_RIGHT_RST);
            r_top    <= COORD_BITS'(lswc_pkg::WIN_TOP_RST);
            r_bottom <= COORD_BITS'(lswc_pkg::WIN_BOTTOM_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lswc_pkg::REG_LEFT:   r_left   <= i_cfg_data;
                lswc_pkg::REG_RIGHT:  r_right  <= i_cfg_data;
                lswc_pkg::REG_TOP:    r_top    <= i_cfg_data;
                lswc_pkg::REG_BOTTOM: r_bottom <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advances unless the output holds a result not taken
    logic n_en;
    assign n_en    = !o_valid || i_ready;
    assign o_ready = n_en;

    // stage 0: outcodes
    function automatic logic [3:0] outcode(
        input logic signed [COORD_BITS-1:0] x, y, l, r, t, b);
        logic [3:0] c;
        c = '0;
        c[lswc_pkg::OC_TOP]    = y < t;
        c[lswc_pkg::OC_BOTTOM] = y > b;
        c[lswc_pkg::OC_RIGHT]  = x > r;
        c[lswc_pkg::OC_LEFT]   = x < l;
        return c;
    endfunction

    logic [3:0] n_c1, n_c2;
    assign n_c1 = outcode(i_start_x, i_start_y, r_left, r_right, r_top, r_bottom);
    assign n_c2 = outcode(i_end_x, i_end_y, r_left, r_right, r_top, r_bottom);

    logic signed [COORD_BITS-1:0] r_x1, r_y1, r_x2, r_y2;
    logic [3:0] r_c1, r_c2;
    lswc_pkg::t_stage_ctl r_ctl [LAT];
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_x1 <= i_start_x;
            r_y1 <= i_start_y;
            r_x2 <= i_end_x;
            r_y2 <= i_end_y;
            r_c1 <= n_c1;
            r_c2 <= n_c2;
        end
    end

    // verdict and valid travel in a control shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_ctl[k] <= '0;
        end else if (n_en) begin
            r_ctl[0].valid   <= i_valid;
            r_ctl[0].verdict <= (|(n_c1 & n_c2)) ? lswc_pkg::VERDICT_REJECT :
                                (|(n_c1 | n_c2)) ? lswc_pkg::VERDICT_CLIP :
                                                   lswc_pkg::VERDICT_INSIDE;
            for (int k = 1; k < LAT; k++) r_ctl[k] <= r_ctl[k-1];
        end
    end

    logic signed [COORD_BITS-1:0] n_sx, n_sy, n_ex, n_ey;
    lswc_mover #(.COORD_BITS(COORD_BITS)) u_move_start (
        .i_clk(i_clk), .i_en(n_en), .i_x1(r_x1), .i_y1(r_y1), .i_x2(r_x2),
        .i_y2(r_y2), .i_code(r_c1), .i_left(r_left), .i_right(r_right),
        .i_top(r_top), .i_bottom(r_bottom), .o_x(n_sx), .o_y(n_sy)
    );
    lswc_mover #(.COORD_BITS(COORD_BITS)) u_move_end (
        .i_clk(i_clk), .i_en(n_en), .i_x1(r_x2), .i_y1(r_y2), .i_x2(r_x1),
        .i_y2(r_y1), .i_code(r_c2), .i_left(r_left), .i_right(r_right),
        .i_top(r_top), .i_bottom(r_bottom), .o_x(n_ex), .o_y(n_ey)
    );

    // output register; a rejected segment shows zeros
    logic r_oval;
    logic [1:0] r_verdict;
    logic signed [COORD_BITS-1:0] r_osx, r_osy, r_oex, r_oey;
    logic n_rej;
    assign n_rej = r_ctl[LAT-1].verdict == lswc_pkg::VERDICT_REJECT;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (n_en) begin
            r_oval <= r_ctl[LAT-1].valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_verdict <= r_ctl[LAT-1].verdict;
            r_osx <= n_rej ? '0 : n_sx;
            r_osy <= n_rej ? '0 : n_sy;
            r_oex <= n_rej ? '0 : n_ex;
            r_oey <= n_rej ? '0 : n_ey;
        end
    end

    assign o_valid           = r_oval;
    assign o_verdict         = r_verdict;
    assign o_clipped_start_x = r_osx;
    assign o_clipped_start_y = r_osy;
    assign o_clipped_end_x   = r_oex;
    assign o_clipped_end_y   = r_oey;

endmodule

### hdl/lswc_divider.sv
// ============================================================================
// lswc_divider: pipelined unsigned restoring divider
// One quotient bit per stage; divides a NUM_BITS numerator by a DEN_BITS
// denominator. Stall enable freezes every stage. Sideband data rides along.
// ============================================================================
module lswc_divider #(
    parameter int NUM_BITS  = 34,
    parameter int DEN_BITS  = 18,
    parameter int SIDE_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [NUM_BITS-1:0]  i_num,
    input  logic [DEN_BITS-1:0]  i_den,
    input  logic [SIDE_BITS-1:0] i_side,
    output logic [NUM_BITS-1:0]  o_quot,
    output logic [SIDE_BITS-1:0] o_side
);

    logic [NUM_BITS-1:0]  r_num  [NUM_BITS+1];
    logic [DEN_BITS:0]    r_rem  [NUM_BITS+1];
    logic [DEN_BITS-1:0]  r_den  [NUM_BITS+1];
    logic [SIDE_BITS-1:0] r_side [NUM_BITS+1];

    // stage 0 loads the operands
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0]  <= i_num;
            r_rem[0]  <= '0;
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    // one restoring step per stage: shift in the top numerator bit
    for (genvar g = 0; g < NUM_BITS; g++) begin : g_step
        logic [DEN_BITS:0] n_shift;
        logic [DEN_BITS:0] n_diff;
        logic              n_ge;
        assign n_shift = {r_rem[g][DEN_BITS-1:0], r_num[g][NUM_BITS-1]};
        assign n_diff  = n_shift - {1'b0, r_den[g]};
        assign n_ge    = n_shift >= {1'b0, r_den[g]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1]  <= n_ge ? n_diff : n_shift;
                r_num[g+1]  <= {r_num[g][NUM_BITS-2:0], n_ge};
                r_den[g+1]  <= r_den[g];
                r_side[g+1] <= r_side[g];
            end
        end
    end

    assign o_quot = r_num[NUM_BITS];
    assign o_side = r_side[NUM_BITS];

endmodule

### hdl/lswc_mover.sv
// ============================================================================
// lswc_mover: moves one outside endpoint onto a window edge
// Stage A forms the side and top/bottom crossing products, a pipelined
// divider pair, one per product, forms both quotients, stage B picks the edge.
// ============================================================================
module lswc_mover #(
    parameter int COORD_BITS = lswc_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [COORD_BITS-1:0] i_x1,
    input  logic signed [COORD_BITS-1:0] i_y1,
    input  logic signed [COORD_BITS-1:0] i_x2,
    input  logic signed [COORD_BITS-1:0] i_y2,
    input  logic [3:0]                   i_code,
    input  logic signed [COORD_BITS-1:0] i_left,
    input  logic signed [COORD_BITS-1:0] i_right,
    input  logic signed [COORD_BITS-1:0] i_top,
    input  logic signed [COORD_BITS-1:0] i_bottom,
    output logic signed [COORD_BITS-1:0] o_x,
    output logic signed [COORD_BITS-1:0] o_y
);

    localparam int D = COORD_BITS + 1;       // difference width
    localparam int P = 2 * D;                // product width
    localparam int W = COORD_BITS + 3;       // result compare width
    // sideband: x1,y1,ex,ey,code,neg_s,neg_t,zero_s,zero_t,top,bottom
    localparam int SB = 6 * COORD_BITS + 8;
    // stage A sideband lacks the four sign/zero flags
    localparam int SA = SB - 4;
    // upper sideband part rides the side divider, the rest the other one
    localparam int SB_S = 4 * COORD_BITS + 6;
    localparam int SB_T = SB - SB_S;

    // stage A: differences and products
    logic signed [D-1:0] n_dx, n_dy, n_ex_off, n_ey_off;
    logic signed [COORD_BITS-1:0] n_ex, n_ey;
    assign n_ex = i_code[lswc_pkg::OC_RIGHT] ? i_right : i_left;
    assign n_ey = i_code[lswc_pkg::OC_BOTTOM] ? i_bottom : i_top;
    assign n_dx = D'(i_x2) - D'(i_x1);
    assign n_dy = D'(i_y2) - D'(i_y1);
    assign n_ex_off = D'(n_ex) - D'(i_x1);
    assign n_ey_off = D'(n_ey) - D'(i_y1);

    logic signed [P-1:0] r_prod_s, r_prod_t;
    logic signed [D-1:0] r_dx, r_dy;
    logic [SA-1:0]       r_side_a;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_s <= n_dy * n_ex_off;
            r_prod_t <= n_dx * n_ey_off;
            r_dx     <= n_dx;
            r_dy     <= n_dy;
            r_side_a <= {i_x1, i_y1, n_ex, n_ey, i_code, i_top, i_bottom};
        end
    end

    // magnitudes and signs for the dividers
    logic [P-1:0] n_mag_s, n_mag_t;
    logic [D-1:0] n_mag_dx, n_mag_dy;
    logic [SB-1:0] n_side_b;
    assign n_mag_s  = r_prod_s[P-1] ? P'(-r_prod_s) : P'(r_prod_s);
    assign n_mag_t  = r_prod_t[P-1] ? P'(-r_prod_t) : P'(r_prod_t);
    assign n_mag_dx = r_dx[D-1] ? D'(-r_dx) : D'(r_dx);
    assign n_mag_dy = r_dy[D-1] ? D'(-r_dy) : D'(r_dy);
    assign n_side_b = {r_side_a[SA-1:2*COORD_BITS],
                       r_prod_s[P-1] ^ r_dx[D-1], r_prod_t[P-1] ^ r_dy[D-1],
                       r_dx == '0, r_dy == '0,
                       r_side_a[2*COORD_BITS-1:0]};

    logic [P-1:0]    n_q_s, n_q_t;
    logic [SB_S-1:0] n_side_cs;
    logic [SB_T-1:0] n_side_ct;
    logic [SB-1:0]   n_side_c;

    lswc_divider #(.NUM_BITS(P), .DEN_BITS(D), .SIDE_BITS(SB_S)) u_div_s (
        .i_clk(i_clk), .i_en(i_en), .i_num(n_mag_s), .i_den(n_mag_dx),
        .i_side(n_side_b[SB-1:SB_T]), .o_quot(n_q_s), .o_side(n_side_cs)
    );
    lswc_divider #(.NUM_BITS(P), .DEN_BITS(D), .SIDE_BITS(SB_T)) u_div_t (
        .i_clk(i_clk), .i_en(i_en), .i_num(n_mag_t), .i_den(n_mag_dy),
        .i_side(n_side_b[SB_T-1:0]), .o_quot(n_q_t), .o_side(n_side_ct)
    );
    assign n_side_c = {n_side_cs, n_side_ct};

    // unpack sideband
    logic signed [COORD_BITS-1:0] c_x1, c_y1, c_ex, c_ey, c_top, c_bot;
    logic [3:0] c_code;
    logic c_neg_s, c_neg_t, c_zs, c_zt;
    assign {c_x1, c_y1, c_ex, c_ey, c_code, c_neg_s, c_neg_t, c_zs, c_zt,
            c_top, c_bot} = n_side_c;

    // stage B: signed offsets and edge selection
    logic signed [W-1:0] n_off_s, n_off_t, n_ny;
    logic signed [P-1:0] n_sq_s, n_sq_t;
    assign n_sq_s  = c_zs ? '0 : (c_neg_s ? -$signed(n_q_s) : $signed(n_q_s));
    assign n_sq_t  = c_zt ? '0 : (c_neg_t ? -$signed(n_q_t) : $signed(n_q_t));
    assign n_off_s = W'(n_sq_s);
    assign n_off_t = W'(n_sq_t);
    assign n_ny    = W'(c_y1) + n_off_s;

    // quotient magnitude is at most 2^(COORD_BITS+1), so W bits hold it exactly
    logic n_side_ok;
    assign n_side_ok = (c_code[lswc_pkg::OC_LEFT] | c_code[lswc_pkg::OC_RIGHT])
                     && (n_ny <= W'(c_bot)) && (n_ny >= W'(c_top));

    always_comb begin
        o_x = c_x1;
        o_y = c_y1;
        if (n_side_ok) begin
            o_x = c_ex;
            o_y = n_ny[COORD_BITS-1:0];
        end else if (c_code[lswc_pkg::OC_TOP] | c_code[lswc_pkg::OC_BOTTOM]) begin
            o_x = COORD_BITS'(W'(c_x1) + n_off_t);
            o_y = c_ey;
        end
    end

endmodule

### hdl/lswc_checker.sv
// ============================================================================
// lswc_checker: port-level checks for the segment clipper
// Watches handshakes and result codes at the top level ports.
// ============================================================================
module lswc_checker #(
    parameter int COORD_BITS = lswc_pkg::COORD_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_ready,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [1:0]            o_verdict,
    input logic [COORD_BITS-1:0] o_clipped_start_x,
    input logic [COORD_BITS-1:0] o_clipped_end_y
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_verdict))
        else $error("result dropped under stall");

    // verdict code is meaningful
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_verdict <= lswc_pkg::VERDICT_INSIDE)
        else $error("bad verdict");

    // rejected segments report zero start x and end y coordinates
    a_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_verdict == lswc_pkg::VERDICT_REJECT |->
        o_clipped_start_x == '0 && o_clipped_end_y == '0)
        else $error("reject with coordinates");

    // ready follows output room
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("accept while stalled");

endmodule

bind line_segment_window_clipper_unit lswc_checker #(.COORD_BITS(COORD_BITS)) u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready), .o_valid(o_valid),
    .i_ready(i_ready), .o_verdict(o_verdict),
    .o_clipped_start_x(o_clipped_start_x), .o_clipped_end_y(o_clipped_end_y)
);

### tb/sv/tb_line_segment_window_clipper_unit.sv
// ----------------------------------------------------------------------------
// tb_line_segment_window_clipper_unit
// Self-checking bench for the segment window clipper. A scoreboard predicts
// the verdict and clipped endpoints of every accepted segment request and
// compares them in order with the results, over several window settings,
// with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_line_segment_window_clipper_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = lswc_pkg::COORD_BITS_DEF;
    localparam int DRAIN_CYCLES = 2 * (W + 1) + 3 + 20;

    typedef logic signed [W-1:0] t_coord;

    typedef struct packed {
        logic [1:0] verdict;
        t_coord     sx;
        t_coord     sy;
        t_coord     ex;
        t_coord     ey;
    } t_clip_res;

    // Scoreboard: window copy, clip predictor, queue of expected results
    class clip_scoreboard;
        longint    win_left, win_right, win_top, win_bottom;
        t_clip_res expected_q[$];
        int        n_err;
        int        n_checked;
        int        n_verdict[3];

        function new();
            win_left = lswc_pkg::WIN_LEFT_RST;
            win_right = lswc_pkg::WIN_RIGHT_RST;
            win_top = lswc_pkg::WIN_TOP_RST;
            win_bottom = lswc_pkg::WIN_BOTTOM_RST;
            n_err = 0;
            n_checked = 0;
            n_verdict = '{0, 0, 0};
        endfunction

        function void set_window(logic [1:0] idx, t_coord val);
            case (idx)
                lswc_pkg::REG_LEFT:   win_left = val;
                lswc_pkg::REG_RIGHT:  win_right = val;
                lswc_pkg::REG_TOP:    win_top = val;
                lswc_pkg::REG_BOTTOM: win_bottom = val;
                default: ;
            endcase
        endfunction

        function logic [3:0] region_code(longint x, longint y);
            logic [3:0] c;
            c = '0;
            if (y < win_top)    c[lswc_pkg::OC_TOP] = 1'b1;
            if (y > win_bottom) c[lswc_pkg::OC_BOTTOM] = 1'b1;
            if (x > win_right)  c[lswc_pkg::OC_RIGHT] = 1'b1;
            if (x < win_left)   c[lswc_pkg::OC_LEFT] = 1'b1;
            return c;
        endfunction

        // a*b/c truncated toward zero, zero divisor gives 0
        function longint cross_offset(longint a, longint b, longint c);
            if (c == 0) return 0;
            return (a * b) / c;
        endfunction

        // move (x1,y1) with region code c onto a window edge toward (x2,y2)
        function void pull_to_edge(longint x1, longint y1, logic [3:0] c,
                                   longint x2, longint y2,
                                   output longint ox, output longint oy);
            longint edge_x, edge_y, ny;
            ox = x1;
            oy = y1;
            if (c[lswc_pkg::OC_LEFT] || c[lswc_pkg::OC_RIGHT]) begin
                edge_x = c[lswc_pkg::OC_RIGHT] ? win_right : win_left;
                ny = y1 + cross_offset(y2 - y1, edge_x - x1, x2 - x1);
                if (ny <= win_bottom && ny >= win_top) begin
                    ox = edge_x;
                    oy = ny;
                    return;
                end
            end
            if (c[lswc_pkg::OC_TOP] || c[lswc_pkg::OC_BOTTOM]) begin
                edge_y = c[lswc_pkg::OC_BOTTOM] ? win_bottom : win_top;
                ox = x1 + cross_offset(x2 - x1, edge_y - y1, y2 - y1);
                oy = edge_y;
            end
        endfunction

        function void note_segment(t_coord x1, t_coord y1, t_coord x2, t_coord y2);
            logic [3:0] c1, c2;
            longint sx, sy, ex, ey;
            t_clip_res r;
            c1 = region_code(x1, y1);
            c2 = region_code(x2, y2);
            sx = 0; sy = 0; ex = 0; ey = 0;
            if ((c1 & c2) != 0) begin
                r.verdict = lswc_pkg::VERDICT_REJECT;
            end else if ((c1 | c2) != 0) begin
                r.verdict = lswc_pkg::VERDICT_CLIP;
                pull_to_edge(x1, y1, c1, x2, y2, sx, sy);
                pull_to_edge(x2, y2, c2, x1, y1, ex, ey);
            end else begin
                r.verdict = lswc_pkg::VERDICT_INSIDE;
                sx = x1; sy = y1; ex = x2; ey = y2;
            end
            r.sx = sx[W-1:0];
            r.sy = sy[W-1:0];
            r.ex = ex[W-1:0];
            r.ey = ey[W-1:0];
            expected_q.push_back(r);
        endfunction

        task report(string what, longint got, longint want);
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
            n_err++;
        endtask

        task check_result(t_clip_res got);
            t_clip_res want;
            if (expected_q.size() == 0) begin
                report("result with no request outstanding", got.verdict, -1);
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            if (want.verdict <= lswc_pkg::VERDICT_INSIDE) n_verdict[want.verdict]++;
            if (got.verdict !== want.verdict) report("verdict", got.verdict, want.verdict);
            if (got.sx !== want.sx) report("clipped_start_x", got.sx, want.sx);
            if (got.sy !== want.sy) report("clipped_start_y", got.sy, want.sy);
            if (got.ex !== want.ex) report("clipped_end_x", got.ex, want.ex);
            if (got.ey !== want.ey) report("clipped_end_y", got.ey, want.ey);
        endtask
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = lswc_pkg::REG_LEFT;
    t_coord     i_cfg_data = '0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    t_coord     i_start_x = '0, i_start_y = '0, i_end_x = '0, i_end_y = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [1:0] o_verdict;
    t_coord     o_clipped_start_x, o_clipped_start_y, o_clipped_end_x, o_clipped_end_y;

    clip_scoreboard sb = new();
    bit stall_req = 1'b0;
    int n_sent = 0;

    line_segment_window_clipper_unit #(.COORD_BITS(W)) dut (.*);

    always #2 i_clk = ~i_clk;

    // Safety net
    initial begin
        #4ms;
        $display("end of test: mismatches");
        $finish;
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result({o_verdict, o_clipped_start_x, o_clipped_start_y,
                             o_clipped_end_x, o_clipped_end_y});
    end

    // Receiver: random hold-offs per result, one long stall on request
    initial begin
        int gap;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (stall_req) begin
                i_ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                stall_req = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    // One segment request; called at a falling edge, returns at one
    task send_segment(t_coord x1, t_coord y1, t_coord x2, t_coord y2);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_start_x <= x1;
        i_start_y <= y1;
        i_end_x <= x2;
        i_end_y <= y2;
        do @(posedge i_clk); while (!o_ready);
        sb.note_segment(x1, y1, x2, y2);
        n_sent++;
        @(negedge i_clk);
    endtask

    // Drain the pipe, then write one window register
    task write_window(logic [1:0] idx, t_coord val);
        i_valid <= 1'b0;
        wait (sb.expected_q.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_window(idx, val);
    endtask

    task set_all(t_coord l, t_coord r, t_coord t, t_coord b);
        write_window(lswc_pkg::REG_LEFT, l);
        write_window(lswc_pkg::REG_RIGHT, r);
        write_window(lswc_pkg::REG_TOP, t);
        write_window(lswc_pkg::REG_BOTTOM, b);
    endtask

    function t_coord sat(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[W-1:0];
    endfunction

    // coordinate near [lo,hi], or anywhere in range now and then
    function t_coord near_span(longint lo, longint hi);
        longint a, b;
        if ($urandom_range(0, 4) == 0) return t_coord'($urandom);
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        a = a - 300;
        b = b + 300;
        return sat(a + longint'($urandom_range(0, 32'(b - a))));
    endfunction

    task random_burst(int n);
        repeat (n)
            send_segment(near_span(sb.win_left, sb.win_right),
                         near_span(sb.win_top, sb.win_bottom),
                         near_span(sb.win_left, sb.win_right),
                         near_span(sb.win_top, sb.win_bottom));
    endtask

    initial begin
        t_coord seg[$][4];
        seg = '{
            '{200, 200, 400, 300},         // wholly inside
            '{150, 100, 450, 350},         // on the window corners
            '{10, 120, 100, 300},          // both left: rejected
            '{500, 120, 600, 300},         // both right: rejected
            '{200, 10, 300, 50},           // both above: rejected
            '{200, 400, 300, 500},         // both below: rejected
            '{50, 200, 300, 250},          // crosses left edge
            '{300, 200, 600, 170},         // crosses right edge
            '{250, 20, 280, 200},          // crosses top edge
            '{250, 200, 230, 500},         // crosses bottom edge
            '{0, 0, 600, 500},             // both ends outside, corners
            '{100, 20, 500, 400},          // side crossing misses, uses top
            '{100, 360, 140, 20},          // outside both ways, both left: rejected
            '{-32768, -32768, 32767, 32767},
            '{32767, -32768, -32768, 32767},
            '{-32768, 200, 32767, 201},    // long shallow line
            '{300, -32768, 301, 32767},    // long steep line
            '{-7, 103, 300, 250},          // start left of the window at a negative x
            '{449, 351, 151, 99}           // barely outside on two sides
        };
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // default window: directed then random
        foreach (seg[k]) send_segment(seg[k][0], seg[k][1], seg[k][2], seg[k][3]);
        random_burst(150);
        // long output stall while requests keep coming
        stall_req = 1'b1;
        random_burst(150);

        // widest window
        set_all(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
        random_burst(150);
        // random window
        set_all(sat(-1000 + int'($urandom_range(0, 900))),
                sat(int'($urandom_range(0, 2000))),
                sat(-1000 + int'($urandom_range(0, 900))),
                sat(int'($urandom_range(0, 2000))));
        random_burst(250);
        // inverted window: left>right, top>bottom
        set_all(400, -400, 300, -300);
        random_burst(200);
        // degenerate window: a single point, zero divisors
        set_all(-5, -5, 7, 7);
        random_burst(200);
        // tiny window near the negative extreme
        set_all(-32768, -32760, -32768, -32764);
        random_burst(150);
        // narrow window near the positive extreme
        set_all(32700, 32767, -20, 20);
        random_burst(150);

        i_valid <= 1'b0;
        wait (sb.expected_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d segments sent over 7 window settings, %0d results checked",
                 n_sent, sb.n_checked);
        $display("rejected %0d, clipped %0d, inside %0d",
                 sb.n_verdict[0], sb.n_verdict[1], sb.n_verdict[2]);
        if (sb.n_err == 0 && sb.expected_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### sim.f
hdl/lswc_pkg.sv
hdl/lswc_divider.sv
hdl/lswc_mover.sv
hdl/line_segment_window_clipper_unit.sv
hdl/lswc_checker.sv
tb/sv/tb_line_segment_window_clipper_unit.sv
